// File: hw/rtl/roc_pkg.sv
// Package for the relay output composer: widths, mode and switch codes,
// sequencer states and the channel-step structs.
// No dependencies; used by roc_step and relay_output_composer.
package roc_pkg;

    localparam int CHANNELS_DEF = 6;
    localparam int VAL_W        = 16;
    localparam int PAUSE_W      = 8;
    localparam int MODE_W       = 3;
    localparam int SW_W         = 2;

    // channel mode codes; anything above MODE_LOCK_SECOND is off
    localparam logic [MODE_W-1:0] MODE_DIRECT      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STATIC      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PULSE       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LOCK_FIRST  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOCK_SECOND = 3'd4;

    // hand switch codes
    localparam logic [SW_W-1:0] SW_AUTO     = 2'd0;
    localparam logic [SW_W-1:0] SW_HAND_OFF = 2'd1;
    localparam logic [SW_W-1:0] SW_HAND_ON  = 2'd2;
    localparam logic [SW_W-1:0] SW_OFF      = 2'd3;

    // item kinds
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    // configuration register indexes
    localparam logic REG_CHANNEL_MODES = 1'b0;
    localparam logic REG_PAUSE_RELOAD  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [SW_W-1:0]    sw;
        logic               direct;
        logic               prev;
        logic               has_next;
        logic               has_prev;
        logic [VAL_W-1:0]   cur_val;
        logic [VAL_W-1:0]   nxt_val;
        logic [PAUSE_W-1:0] cur_pause;
        logic [PAUSE_W-1:0] prv_pause;
        logic [PAUSE_W-1:0] counter;
        logic [PAUSE_W-1:0] reload;
    } step_in_t;

    typedef struct packed {
        logic               bit_on;
        logic [VAL_W-1:0]   cur_val;
        logic [VAL_W-1:0]   nxt_val;
        logic [PAUSE_W-1:0] cur_pause;
        logic [PAUSE_W-1:0] prv_pause;
        logic [PAUSE_W-1:0] counter;
    } step_out_t;

endpackage

// File: hw/rtl/roc_step.sv
// Shared channel-step unit: evaluates one channel per cycle and returns its
// output bit and the updated values. Depends on roc_pkg.
module roc_step (
    input  roc_pkg::step_in_t  si,
    output roc_pkg::step_out_t so
);
    import roc_pkg::*;

    logic [VAL_W-1:0]   val_dec;
    logic [PAUSE_W-1:0] pause_sel;
    logic [PAUSE_W-1:0] pause_dec;
    logic               val_nz;
    logic               partner;

    assign val_nz    = (si.cur_val != '0);
    assign val_dec   = si.cur_val - VAL_W'(1);
    assign pause_sel = (si.mode == MODE_LOCK_FIRST) ? si.cur_pause : si.prv_pause;
    assign pause_dec = pause_sel - PAUSE_W'(1);
    assign partner   = si.has_next && (si.nxt_val != '0);

    always_comb
    begin
        so.bit_on    = 1'b0;
        so.cur_val   = si.cur_val;
        so.nxt_val   = si.nxt_val;
        so.cur_pause = si.cur_pause;
        so.prv_pause = si.prv_pause;
        so.counter   = si.counter;
        if (si.sw != SW_AUTO)
        begin
            so.bit_on = (si.sw == SW_HAND_ON);
        end
        else
        begin
            case (si.mode)
                MODE_DIRECT:
                begin
                    so.bit_on = si.direct;
                end
                MODE_STATIC:
                begin
                    if (val_nz)
                    begin
                        if (si.prev)
                        begin
                            so.bit_on = 1'b1;
                        end
                        else if (si.counter == '0)
                        begin
                            so.bit_on  = 1'b1;
                            so.counter = si.reload;
                        end
                    end
                end
                MODE_PULSE:
                begin
                    if (val_nz)
                    begin
                        so.bit_on  = 1'b1;
                        so.cur_val = val_dec;
                    end
                end
                MODE_LOCK_FIRST:
                begin
                    if (val_nz)
                    begin
                        if (partner)
                        begin
                            // changeover: clear the partner's value if this channel was not on, else this channel's own
                            if (!si.prev)
                            begin
                                so.nxt_val = '0;
                            end
                            else
                            begin
                                so.cur_val = '0;
                            end
                            so.cur_pause = PAUSE_W'(1);
                        end
                        else if (si.cur_pause != '0)
                        begin
                            so.cur_pause = pause_dec;
                        end
                        else
                        begin
                            so.bit_on  = 1'b1;
                            so.cur_val = val_dec;
                        end
                    end
                end
                MODE_LOCK_SECOND:
                begin
                    if (val_nz)
                    begin
                        if (si.has_prev && (si.prv_pause != '0))
                        begin
                            so.prv_pause = pause_dec;
                        end
                        else
                        begin
                            so.bit_on  = 1'b1;
                            so.cur_val = val_dec;
                        end
                    end
                end
                default:
                begin
                    so.bit_on = 1'b0;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/relay_output_composer.sv
// Relay output composer top level: sequencer, rotating channel state and
// output register around the shared channel-step unit.
// Depends on roc_pkg and roc_step.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  req_type channel load_value switch_states direct_data
//   out      output     out_valid/out_stall relay_bits pause_active
//   cfg      input      cfg_write          cfg_index cfg_data
//
// A tick item is accepted in ST_IDLE, walks each channel through the shared step
// unit in ST_WALK and loads the output register in ST_DONE; a load item skips
// ST_WALK. in_stall is high from acceptance until the result sits in the output
// register; a waiting result does not block acceptance of the next item, which then
// waits in ST_DONE for it. Reset clears control, config, values and pauses, not output data.
module relay_output_composer #(
    parameter int CHANNELS = roc_pkg::CHANNELS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   req_type,
    input  logic [2:0]                             channel,
    input  logic [roc_pkg::VAL_W-1:0]              load_value,
    input  logic [2*CHANNELS-1:0]                  switch_states,
    input  logic [CHANNELS-1:0]                    direct_data,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [CHANNELS-1:0]                    relay_bits,
    output logic                                   pause_active,
    input  logic                                   cfg_write,
    input  logic                                   cfg_index,
    input  logic [((3*CHANNELS > 8) ? 3*CHANNELS : 8)-1:0] cfg_data
);
    import roc_pkg::*;

    localparam int MODES_W = MODE_W * CHANNELS;
    localparam int CNT_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NXT     = (CHANNELS > 1) ? 1 : 0;
    localparam int PRV     = CHANNELS - 1;

    state_t state_reg, state_next;

    logic [MODES_W-1:0]  modes_reg;
    logic [PAUSE_W-1:0]  reload_reg;
    logic [VAL_W-1:0]    val_reg   [CHANNELS];
    logic [PAUSE_W-1:0]  pause_reg [CHANNELS];
    logic [VAL_W-1:0]    val_upd   [CHANNELS];
    logic [PAUSE_W-1:0]  pause_upd [CHANNELS];
    logic [CHANNELS-1:0] prev_reg;
    logic [PAUSE_W-1:0]  counter_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [MODES_W-1:0]  sh_mode_reg;
    logic [2*CHANNELS-1:0] sh_sw_reg;
    logic [CHANNELS-1:0] sh_dir_reg;
    logic [CHANNELS-1:0] sh_prev_reg;
    logic [CHANNELS-1:0] bits_reg;
    logic [CHANNELS-1:0] bits_shift;
    logic                out_valid_reg;
    logic [CHANNELS-1:0] relay_bits_reg;
    logic                pause_active_reg;

    logic      in_take;
    logic      out_take;
    logic      out_free;
    logic      last_step;
    logic      load_hit;
    step_in_t  si;
    step_out_t so;

    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_step = (idx_reg == CNT_W'(CHANNELS - 1));
    assign load_hit  = ({1'b0, channel} < 4'(CHANNELS));

    // new bit enters at the top, so channel 0 ends at bit 0 after the walk
    assign bits_shift = CHANNELS'({so.bit_on, bits_reg} >> 1);

    assign out_valid    = out_valid_reg;
    assign relay_bits   = relay_bits_reg;
    assign pause_active = pause_active_reg;

    // channel under the step unit sits at position 0 of every shift line
    always_comb
    begin
        si.mode      = sh_mode_reg[MODE_W-1:0];
        si.sw        = sh_sw_reg[SW_W-1:0];
        si.direct    = sh_dir_reg[0];
        si.prev      = sh_prev_reg[0];
        si.has_next  = !last_step;
        si.has_prev  = (idx_reg != '0);
        si.cur_val   = val_reg[0];
        si.nxt_val   = val_reg[NXT];
        si.cur_pause = pause_reg[0];
        si.prv_pause = pause_reg[PRV];
        si.counter   = counter_reg;
        si.reload    = reload_reg;
    end

    roc_step u_step (
        .si (si),
        .so (so)
    );

    // merge the step results, later writes win where positions coincide
    always_comb
    begin
        for (int k = 0; k < CHANNELS; k++)
        begin
            val_upd[k]   = val_reg[k];
            pause_upd[k] = pause_reg[k];
        end
        val_upd[NXT]   = so.nxt_val;
        val_upd[0]     = so.cur_val;
        pause_upd[PRV] = so.prv_pause;
        pause_upd[0]   = so.cur_pause;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = (req_type == REQ_TICK) ? ST_WALK : ST_DONE;
                end
            end
            ST_WALK:
            begin
                if (last_step)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: in_stall = 1'b0;
            ST_WALK: in_stall = 1'b1;
            ST_DONE: in_stall = 1'b1;
            default: in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modes_reg  <= '0;
            reload_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CHANNEL_MODES: modes_reg  <= cfg_data[MODES_W-1:0];
                REG_PAUSE_RELOAD:  reload_reg <= cfg_data[PAUSE_W-1:0];
                default:           modes_reg  <= modes_reg;
            endcase
        end
    end

    // channel state: rotate one place per step so the next channel comes to position 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                val_reg[k]   <= '0;
                pause_reg[k] <= '0;
            end
            prev_reg    <= '0;
            counter_reg <= '0;
            idx_reg     <= '0;
            bits_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        if (req_type == REQ_LOAD)
                        begin
                            if (load_hit)
                            begin
                                val_reg[channel[CNT_W-1:0]] <= load_value;
                            end
                        end
                        else
                        begin
                            if (counter_reg != '0)
                            begin
                                counter_reg <= counter_reg - PAUSE_W'(1);
                            end
                            idx_reg <= '0;
                        end
                    end
                end
                ST_WALK:
                begin
                    for (int k = 0; k < CHANNELS; k++)
                    begin
                        val_reg[k]   <= val_upd[(k + 1) % CHANNELS];
                        pause_reg[k] <= pause_upd[(k + 1) % CHANNELS];
                    end
                    counter_reg <= so.counter;
                    idx_reg     <= idx_reg + CNT_W'(1);
                    bits_reg    <= bits_shift;
                    if (last_step)
                    begin
                        prev_reg <= bits_shift;
                    end
                end
                ST_DONE:
                begin
                    idx_reg <= '0;
                end
                default:
                begin
                    idx_reg <= '0;
                end
            endcase
        end
    end

    // per-tick snapshots, shifted one channel per step
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            sh_mode_reg <= modes_reg;
            sh_sw_reg   <= switch_states;
            sh_dir_reg  <= direct_data;
            sh_prev_reg <= prev_reg;
        end
        else
        begin
            sh_mode_reg <= sh_mode_reg >> MODE_W;
            sh_sw_reg   <= sh_sw_reg >> SW_W;
            sh_dir_reg  <= sh_dir_reg >> 1;
            sh_prev_reg <= sh_prev_reg >> 1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_DONE) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_free)
        begin
            relay_bits_reg   <= prev_reg;
            pause_active_reg <= (counter_reg != '0);
        end
    end

endmodule

// File: tb/sv/tb_relay_output_composer.sv
// Self-checking testbench for relay_output_composer: random-timed item driver,
// output monitor with its own cycle-free model of the relay channel walk.
// Depends on roc_pkg and the relay_output_composer RTL.
`timescale 1ns / 100ps

module tb_relay_output_composer;

    import roc_pkg::*;

    localparam int CH             = CHANNELS_DEF;
    localparam int CFG_W          = (3 * CH > 8) ? 3 * CH : 8;
    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 12;
    localparam int DRAIN_CYCLES   = 20;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int MAX_SHOWN      = 10;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 175;
    localparam int HOLD_AFTER     = 400;
    localparam int HOLD_CYCLES    = 300;

    // off codes above the last real mode
    localparam logic [MODE_W-1:0] MODE_OFF5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_OFF6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_OFF7 = 3'd7;

    typedef struct packed {
        logic                kind;
        logic [2:0]          chan;
        logic [VAL_W-1:0]    value;
        logic [2*CH-1:0]     sw;
        logic [CH-1:0]       direct;
    } relay_req_t;

    typedef struct packed {
        logic [CH-1:0] bits;
        logic          pause;
    } relay_res_t;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic                  req_type      = REQ_TICK;
    logic [2:0]            channel       = '0;
    logic [VAL_W-1:0]      load_value    = '0;
    logic [2*CH-1:0]       switch_states = '0;
    logic [CH-1:0]         direct_data   = '0;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic [CH-1:0]         relay_bits;
    logic                  pause_active;
    logic                  cfg_write     = 1'b0;
    logic                  cfg_index     = REG_CHANNEL_MODES;
    logic [CFG_W-1:0]      cfg_data      = '0;

    logic                  in_fire       = 1'b0;
    logic                  out_fire      = 1'b0;
    logic                  long_hold     = 1'b0;

    relay_req_t            req_backlog[$];
    relay_res_t            relay_out_due[$];
    int                    total_queued   = 0;
    int                    accepted_items = 0;
    int                    results_seen   = 0;
    int                    mismatches     = 0;
    int                    send_wait      = 0;
    int                    recv_wait      = 0;
    int                    tx_quiet       = 0;
    int                    rx_quiet       = 0;

    // model state
    logic [VAL_W-1:0]      chan_value     [CH];
    logic [PAUSE_W-1:0]    handover_pause [CH];
    logic [CH-1:0]         last_bits;
    logic [PAUSE_W-1:0]    pause_left;
    logic [3*CH-1:0]       mode_word;
    logic [PAUSE_W-1:0]    pause_reload;

    relay_output_composer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .channel       (channel),
        .load_value    (load_value),
        .switch_states (switch_states),
        .direct_data   (direct_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .relay_bits    (relay_bits),
        .pause_active  (pause_active),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Walk the channels in order, each one seeing what earlier ones changed.
    function automatic relay_res_t compose_relay_bits(input relay_req_t r);
        relay_res_t       res;
        logic [CH-1:0]    bits;
        logic [SW_W-1:0]  sw;
        logic [MODE_W-1:0] mode;
        logic             partner;
        bits = '0;
        if (r.kind == REQ_LOAD)
        begin
            if (r.chan < CH)
                chan_value[r.chan] = r.value;
        end
        else
        begin
            if (pause_left != 0)
                pause_left = pause_left - 1'b1;
            for (int i = 0; i < CH; i++)
            begin
                sw   = r.sw[2*i +: 2];
                mode = mode_word[3*i +: 3];
                if (sw != SW_AUTO)
                begin
                    if (sw == SW_HAND_ON)
                        bits[i] = 1'b1;
                end
                else
                begin
                    case (mode)
                        MODE_DIRECT:
                            bits[i] = r.direct[i];
                        MODE_STATIC:
                            if (chan_value[i] != 0)
                            begin
                                if (last_bits[i])
                                    bits[i] = 1'b1;
                                else if (pause_left == 0)
                                begin
                                    bits[i]    = 1'b1;
                                    pause_left = pause_reload;
                                end
                            end
                        MODE_PULSE:
                            if (chan_value[i] != 0)
                            begin
                                bits[i]       = 1'b1;
                                chan_value[i] = chan_value[i] - 1'b1;
                            end
                        MODE_LOCK_FIRST:
                            if (chan_value[i] != 0)
                            begin
                                // the last channel has no partner: treat it as idle
                                partner = 1'b0;
                                if (i + 1 < CH)
                                    partner = (chan_value[i + 1] != 0);
                                if (partner)
                                begin
                                    if (!last_bits[i])
                                        chan_value[i + 1] = '0;
                                    else
                                        chan_value[i] = '0;
                                    handover_pause[i] = 8'd1;
                                end
                                else if (handover_pause[i] != 0)
                                    handover_pause[i] = handover_pause[i] - 1'b1;
                                else
                                begin
                                    bits[i]       = 1'b1;
                                    chan_value[i] = chan_value[i] - 1'b1;
                                end
                            end
                        MODE_LOCK_SECOND:
                            if (chan_value[i] != 0)
                            begin
                                if (i > 0 && handover_pause[i - 1] != 0)
                                    handover_pause[i - 1] = handover_pause[i - 1] - 1'b1;
                                else
                                begin
                                    bits[i]       = 1'b1;
                                    chan_value[i] = chan_value[i] - 1'b1;
                                end
                            end
                        default:
                            ;
                    endcase
                end
            end
            last_bits = bits;
        end
        res.bits  = last_bits;
        res.pause = (pause_left != 0);
        return res;
    endfunction

    // Mostly random gaps, with occasional stretches of none.
    function automatic int draw_gap(inout int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            quiet = $urandom_range(10, 40);
        return $urandom_range(0, 12);
    endfunction

    // Favour interlock pairs so the changeover logic gets exercised.
    function automatic logic [3*CH-1:0] draw_modes();
        logic [3*CH-1:0] m;
        int              i;
        m = '0;
        i = 0;
        while (i < CH)
        begin
            if (i + 1 < CH && $urandom_range(0, 2) == 0)
            begin
                m[3*i +: 3]       = MODE_LOCK_FIRST;
                m[3*(i + 1) +: 3] = MODE_LOCK_SECOND;
                i += 2;
            end
            else
            begin
                if ($urandom_range(0, 4) == 0)
                    m[3*i +: 3] = 3'($urandom_range(5, 7));
                else
                    m[3*i +: 3] = 3'($urandom_range(0, 4));
                i++;
            end
        end
        return m;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endtask

    task automatic offer(input logic kind, input logic [2:0] chan, input logic [VAL_W-1:0] value,
                         input logic [2*CH-1:0] sw, input logic [CH-1:0] direct);
        relay_req_t r;
        r.kind   = kind;
        r.chan   = chan;
        r.value  = value;
        r.sw     = sw;
        r.direct = direct;
        req_backlog.push_back(r);
        total_queued++;
    endtask

    task automatic offer_random();
        logic [2:0]       chan;
        logic [VAL_W-1:0] value;
        logic [2*CH-1:0]  sw;
        int               k;
        if ($urandom_range(0, 9) == 0)
            chan = 3'($urandom_range(CH, 7));
        else
            chan = 3'($urandom_range(0, CH - 1));
        k = $urandom_range(0, 19);
        if (k < 3)
            value = '0;
        else if (k < 5)
            value = '1;
        else if (k < 8)
            value = VAL_W'($urandom);
        else
            value = VAL_W'($urandom_range(1, 8));
        for (int i = 0; i < CH; i++)
            sw[2*i +: 2] = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : SW_AUTO;
        offer(($urandom_range(0, 99) < 35) ? REQ_LOAD : REQ_TICK, chan, value, sw,
              CH'($urandom_range(0, (1 << CH) - 1)));
    endtask

    // Let everything queued so far come back before touching registers.
    task automatic wait_idle();
        wait (results_seen >= total_queued);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [3*CH-1:0] modes, input logic [PAUSE_W-1:0] reload);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_CHANNEL_MODES;
        cfg_data  <= CFG_W'(modes);
        @(negedge clk);
        cfg_index <= REG_PAUSE_RELOAD;
        cfg_data  <= CFG_W'(reload);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // item driver
    always @(negedge clk)
    begin : driver
        relay_req_t nxt;
        if (rst_n)
        begin
            if (!in_valid || in_fire)
            begin
                if (in_valid)
                    send_wait = draw_gap(tx_quiet);
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (req_backlog.size() > 0)
                begin
                    nxt = req_backlog.pop_front();
                    in_valid      <= 1'b1;
                    req_type      <= nxt.kind;
                    channel       <= nxt.chan;
                    load_value    <= nxt.value;
                    switch_states <= nxt.sw;
                    direct_data   <= nxt.direct;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
                recv_wait = draw_gap(rx_quiet);
            if (long_hold)
                out_stall <= 1'b1;
            else if (recv_wait > 0)
            begin
                recv_wait--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Hold the output for a long stretch while items keep coming, so the block backs up.
    initial
    begin
        wait (accepted_items >= HOLD_AFTER);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    // monitor: check results first, then register writes, then predict new items
    always @(posedge clk)
    begin : monitor
        relay_res_t want;
        relay_req_t seen_req;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (relay_out_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("result relay_bits=%0h pause_active=%0b with nothing due",
                                 relay_bits, pause_active);
                end
                else
                begin
                    want = relay_out_due.pop_front();
                    if (want.bits !== relay_bits)
                        note_mismatch("relay_bits", want.bits, relay_bits);
                    if (want.pause !== pause_active)
                        note_mismatch("pause_active", want.pause, pause_active);
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == REG_CHANNEL_MODES)
                    mode_word = cfg_data[3*CH-1:0];
                else
                    pause_reload = cfg_data[PAUSE_W-1:0];
            end
            if (in_valid && !in_stall)
            begin
                seen_req = {req_type, channel, load_value, switch_states, direct_data};
                relay_out_due.push_back(compose_relay_bits(seen_req));
                accepted_items++;
            end
            in_fire  <= in_valid && !in_stall;
            out_fire <= out_valid && !out_stall;
        end
    end

    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("tb_relay_output_composer: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic [3*CH-1:0]    modes;
        logic [PAUSE_W-1:0] reload;
        for (int i = 0; i < CH; i++)
        begin
            chan_value[i]     = '0;
            handover_pause[i] = '0;
        end
        last_bits    = '0;
        pause_left   = '0;
        mode_word    = '0;
        pause_reload = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // all channels direct after reset; hand switches and ignored loads
        offer(REQ_TICK, 3'd0, '0, {CH{SW_AUTO}}, '1);
        offer(REQ_TICK, 3'd0, '0, {CH{SW_AUTO}}, '0);
        offer(REQ_TICK, 3'd0, '0, {CH{SW_HAND_ON}}, '0);
        offer(REQ_TICK, 3'd0, '0, {CH{SW_HAND_OFF}}, '1);
        offer(REQ_TICK, 3'd0, '0, {CH{SW_OFF}}, '1);
        offer(REQ_TICK, 3'd0, '0, {SW_OFF, SW_HAND_ON, SW_HAND_OFF, SW_AUTO, SW_AUTO, SW_AUTO},
              6'h15);
        offer(REQ_LOAD, 3'd7, '1, '0, '0);
        offer(REQ_LOAD, 3'd6, 16'h1234, '0, '0);
        wait_idle();

        // static, pulse, an interlock pair, an off code and a partnerless first
        set_config({MODE_LOCK_FIRST, MODE_OFF5, MODE_LOCK_SECOND, MODE_LOCK_FIRST,
                    MODE_PULSE, MODE_STATIC}, 8'd3);
        offer(REQ_LOAD, 3'd0, 16'd1, '0, '0);
        offer(REQ_LOAD, 3'd1, 16'd2, '0, '0);
        offer(REQ_LOAD, 3'd2, 16'd2, '0, '0);
        offer(REQ_LOAD, 3'd3, 16'd2, '0, '0);
        offer(REQ_LOAD, 3'd5, 16'd1, '0, '0);
        repeat (5) offer(REQ_TICK, 3'd0, '0, {CH{SW_AUTO}}, '0);
        wait_idle();

        // second with no partner on channel 0; two statics sharing a long pause
        set_config({MODE_OFF7, MODE_OFF6, MODE_PULSE, MODE_STATIC, MODE_STATIC,
                    MODE_LOCK_SECOND}, 8'hFF);
        offer(REQ_LOAD, 3'd0, 16'd1, '0, '0);
        offer(REQ_LOAD, 3'd1, '1, '0, '0);
        offer(REQ_LOAD, 3'd2, 16'd1, '0, '0);
        offer(REQ_LOAD, 3'd3, '1, '0, '0);
        repeat (3) offer(REQ_TICK, 3'd0, '0, {CH{SW_AUTO}}, '0);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    modes  = '0;
                    reload = '1;
                end
                1:
                begin
                    modes  = '1;
                    reload = '0;
                end
                3:
                begin
                    modes  = {CH{MODE_STATIC}};
                    reload = 8'd2;
                end
                default:
                begin
                    modes  = draw_modes();
                    reload = (p % 2 == 1) ? PAUSE_W'($urandom_range(0, 3))
                                          : PAUSE_W'($urandom_range(0, 255));
                    if (p == RANDOM_PHASES - 1)
                        reload = '1;
                end
            endcase
            set_config(modes, reload);
            repeat (PHASE_ITEMS) offer_random();
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && relay_out_due.size() == 0)
            $display("tb_relay_output_composer: PASS");
        else
            $display("tb_relay_output_composer: FAIL");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/roc_pkg.sv
hw/rtl/roc_step.sv
hw/rtl/relay_output_composer.sv
tb/sv/tb_relay_output_composer.sv
